// ===== rtl/spds_pkg.sv =====
package spds_pkg;

  // command codes
  typedef enum logic [2:0] {
    CMD_REQUEST = 3'd0,
    CMD_KICK    = 3'd1,
    CMD_POP     = 3'd2,
    CMD_REGISTER = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_t;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;

  // device codes
  localparam logic [1:0] DEV_UNSET = 2'd0;
  localparam logic [1:0] DEV_NPU   = 2'd1;
  localparam logic [1:0] DEV_VPU   = 2'd2;

  // configuration register indexes
  localparam logic REG_SLACK_GAIN = 1'b0;
  localparam logic REG_RUN_CAP    = 1'b1;

  // register reset values
  localparam logic [9:0] SLACK_GAIN_RST = 10'd1;
  localparam logic [9:0] RUN_CAP_RST    = 10'd10;

  // priority arithmetic
  localparam logic [63:0] OVERDUE_PENALTY = 64'd1000;
  localparam logic signed [63:0] PRIO_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] PRIO_MIN = 64'sh8000_0000_0000_0000;
  // negative magnitudes at or above this land on the minimum after the penalty
  localparam logic [63:0] NEG_SAT_LIM = 64'h8000_0000_0000_0000 - 64'd999;

  // counter ceilings
  localparam logic [15:0] STREAK_MAX   = 16'hFFFF;
  localparam logic [31:0] GRANTS_MAX   = 32'hFFFF_FFFF;
  localparam logic [7:0]  INFLIGHT_MAX = 8'hFF;

endpackage

// ===== rtl/slack_priority_dual_device_scheduler.sv =====
// Job scheduler for two devices (NPU and VPU) over a table of JOBS entries.
// Commands enter on start/busy: a beat is taken when start is high and busy
// is low. Each command gives exactly one result, shown for one cycle on the
// out_ ports with out_valid high; the receiver cannot hold it off.
// Pop, register, clear and unknown commands run in S_EXEC, then S_FIN, and
// show their result once S_FIN is done. A request or kick runs a priority
// pass over the table with one shared 32x10 multiplier, two passes per 64-bit
// slack: a used entry goes through the slack, low product, high product, sum
// and priority write steps, and an unused entry is skipped. Then come a
// selection scan for the NPU, skipped when the ring is full or the owner is
// taken, and one for the VPU, one entry per cycle with a single compare unit
// until a forced entry ends the scan, plus a grant step each. busy drops while
// the result is shown, so the next command may be taken at the edge that ends
// the result cycle.
// Configuration writes (cfg_valid, always ready) are taken at any time but
// are meant only while the block is idle.
// Reset clears the table, the NPU ring, the owner and the last grant, and
// loads the slack gain with 1 and the run cap with 10. A clear command empties
// the table, ring and owner but keeps the registers and the last grant.
module slack_priority_dual_device_scheduler #(
  parameter int JOBS       = 16,
  parameter int RING_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_job_index,
  input  logic [1:0]  in_target_device,
  input  logic        in_must_resume,
  input  logic [63:0] in_now_ns,
  input  logic [63:0] in_deadline_ns,
  input  logic        in_active,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_npu_granted,
  output logic [3:0]  out_npu_job,
  output logic        out_vpu_granted,
  output logic [3:0]  out_vpu_job,
  output logic        out_retry_npu,
  output logic        out_retry_vpu,
  output logic [3:0]  out_popped_job,
  output logic [2:0]  out_queue_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int JW = $clog2(JOBS);
  localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam logic [JW-1:0] LAST_JOB  = JW'(JOBS - 1);
  localparam logic [RW-1:0] LAST_SLOT = RW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] RING_FULL = CW'(RING_DEPTH);
  localparam logic [6:0]    JOBS_LIM  = 7'(JOBS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SLACK,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_PRIO_WR,
    S_NPU_CHECK,
    S_SCAN,
    S_GRANT,
    S_FIN
  } state_t;

  state_t state_r;

  // configuration registers
  logic [9:0] slack_gain_r;
  logic [9:0] run_cap_r;

  // job table
  logic                used_r     [JOBS];
  logic [63:0]         deadline_r [JOBS];
  logic [1:0]          device_r   [JOBS];
  logic                waiting_r  [JOBS];
  logic                force_r    [JOBS];
  logic [7:0]          inflight_r [JOBS];
  logic signed [63:0]  prio_r     [JOBS];
  logic [15:0]         streak_r   [JOBS];
  logic [31:0]         grants_r   [JOBS];

  logic          last_v_r;
  logic [JW-1:0] last_r;
  logic          owner_v_r;
  logic [JW-1:0] owner_r;

  // npu completion ring
  logic [JW-1:0] ring_r [RING_DEPTH];
  logic [RW-1:0] head_r;
  logic [RW-1:0] tail_r;
  logic [CW-1:0] count_r;

  // latched command
  logic [2:0]  cmd_r;
  logic [3:0]  idx_r;
  logic [1:0]  dev_in_r;
  logic        must_r;
  logic [63:0] now_r;
  logic [63:0] dl_in_r;
  logic        active_r;

  // priority datapath
  logic [JW-1:0] i_r;
  logic          neg_r;
  logic [63:0]   mag_r;
  logic [41:0]   lo_r;
  logic [41:0]   hi_r;
  logic [73:0]   sum_r;

  // selection scan
  logic [1:0]         scan_dev_r;
  logic               frc_v_r;
  logic [JW-1:0]      frc_r;
  logic               yld_v_r;
  logic [JW-1:0]      yld_r;
  logic               sel_v_r;
  logic [JW-1:0]      sel_r;
  logic signed [63:0] sel_pri_r;
  logic [31:0]        sel_gr_r;
  logic               tgt_v_r;
  logic [JW-1:0]      tgt_r;
  logic signed [63:0] tgt_pri_r;
  logic [31:0]        tgt_gr_r;

  // result registers
  logic       out_valid_r;
  logic [1:0] status_r;
  logic       npu_gr_r;
  logic [3:0] npu_job_r;
  logic       vpu_gr_r;
  logic [3:0] vpu_job_r;
  logic       retry_npu_r;
  logic       retry_vpu_r;
  logic [3:0] popped_r;
  logic [2:0] qcount_r;

  // request entry and its checks
  logic [JW-1:0] k;
  logic          req_bad;
  assign k = JW'(idx_r);
  assign req_bad = ({3'b0, idx_r} >= JOBS_LIM) ||
                   ((dev_in_r != spds_pkg::DEV_NPU) && (dev_in_r != spds_pkg::DEV_VPU)) ||
                   !used_r[k];

  // slack of the scanned entry
  logic [63:0] diff_fw;
  logic [63:0] diff_bw;
  assign diff_fw = deadline_r[i_r] - now_r;
  assign diff_bw = now_r - deadline_r[i_r];

  // scan compare unit
  logic elig;
  logic yield_hit;
  logic prio_win;
  logic grant_win;
  assign elig = used_r[i_r] && (device_r[i_r] == scan_dev_r) && !waiting_r[i_r] &&
                !((scan_dev_r == spds_pkg::DEV_VPU) && (inflight_r[i_r] != 8'd0));
  assign yield_hit = (run_cap_r != 10'd0) && last_v_r && (last_r == i_r) &&
                     (streak_r[i_r] >= {6'b0, run_cap_r});
  assign prio_win = !sel_v_r || (prio_r[i_r] < sel_pri_r) ||
                    ((prio_r[i_r] == sel_pri_r) && (grants_r[i_r] < sel_gr_r));
  assign grant_win = !tgt_v_r || (grants_r[i_r] < tgt_gr_r) ||
                     ((grants_r[i_r] == tgt_gr_r) && (prio_r[i_r] < tgt_pri_r));

  // final pick of a scan
  logic          pick_v;
  logic [JW-1:0] pick;
  assign pick_v = frc_v_r || sel_v_r || yld_v_r;
  always_comb begin
    if (frc_v_r) begin
      pick = frc_r;
    end else if (yld_v_r && tgt_v_r) begin
      pick = tgt_r;
    end else if (sel_v_r) begin
      pick = sel_r;
    end else begin
      pick = yld_r;
    end
  end

  // pop slot
  logic [JW-1:0] pop_j;
  assign pop_j = ring_r[head_r];

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slack_gain_r <= spds_pkg::SLACK_GAIN_RST;
      run_cap_r    <= spds_pkg::RUN_CAP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        spds_pkg::REG_SLACK_GAIN: slack_gain_r <= cfg_data;
        spds_pkg::REG_RUN_CAP:    run_cap_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ring payload, no reset
  always_ff @(posedge clk) begin
    if (state_r == S_GRANT && scan_dev_r == spds_pkg::DEV_NPU && pick_v) begin
      ring_r[tail_r] <= pick;
    end
  end

  // sequencer, table and results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_v_r    <= 1'b0;
      last_r      <= '0;
      owner_v_r   <= 1'b0;
      owner_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      for (int j = 0; j < JOBS; j++) begin
        used_r[j]     <= 1'b0;
        device_r[j]   <= spds_pkg::DEV_UNSET;
        waiting_r[j]  <= 1'b0;
        force_r[j]    <= 1'b0;
        inflight_r[j] <= '0;
        streak_r[j]   <= '0;
        grants_r[j]   <= '0;
      end
    end else begin
      out_valid_r <= (state_r == S_FIN);
      case (state_r)
        // take a command
        S_IDLE: begin
          if (start) begin
            cmd_r       <= in_command;
            idx_r       <= in_job_index;
            dev_in_r    <= in_target_device;
            must_r      <= in_must_resume;
            now_r       <= in_now_ns;
            dl_in_r     <= in_deadline_ns;
            active_r    <= in_active;
            status_r    <= spds_pkg::STAT_OK;
            npu_gr_r    <= 1'b0;
            npu_job_r   <= '0;
            vpu_gr_r    <= 1'b0;
            vpu_job_r   <= '0;
            retry_npu_r <= 1'b0;
            retry_vpu_r <= 1'b0;
            popped_r    <= '0;
            state_r     <= S_EXEC;
          end
        end

        // decode and run the short commands
        S_EXEC: begin
          i_r     <= '0;
          case (cmd_r)
            spds_pkg::CMD_REQUEST: begin
              if (req_bad) begin
                status_r <= spds_pkg::STAT_INVALID;
                state_r  <= S_FIN;
              end else begin
                if (device_r[k] == spds_pkg::DEV_NPU && owner_v_r && owner_r == k) begin
                  owner_v_r <= 1'b0;
                end
                if (device_r[k] == spds_pkg::DEV_VPU && inflight_r[k] != 8'd0) begin
                  inflight_r[k] <= inflight_r[k] - 8'd1;
                end
                device_r[k]  <= dev_in_r;
                waiting_r[k] <= 1'b0;
                force_r[k]   <= (dev_in_r == spds_pkg::DEV_NPU) && must_r;
                state_r      <= S_SLACK;
              end
            end
            spds_pkg::CMD_KICK: begin
              state_r <= S_SLACK;
            end
            spds_pkg::CMD_POP: begin
              state_r <= S_FIN;
              if (count_r == '0) begin
                status_r <= spds_pkg::STAT_EMPTY;
              end else begin
                head_r   <= (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
                count_r  <= count_r - 1'b1;
                popped_r <= 4'(pop_j);
                if (inflight_r[pop_j] != 8'd0) begin
                  inflight_r[pop_j] <= inflight_r[pop_j] - 8'd1;
                end
              end
            end
            spds_pkg::CMD_REGISTER: begin
              state_r <= S_FIN;
              if ({3'b0, idx_r} >= JOBS_LIM) begin
                status_r <= spds_pkg::STAT_INVALID;
              end else begin
                used_r[k]     <= active_r;
                deadline_r[k] <= dl_in_r;
              end
            end
            spds_pkg::CMD_CLEAR: begin
              state_r   <= S_FIN;
              owner_v_r <= 1'b0;
              owner_r   <= '0;
              head_r    <= '0;
              tail_r    <= '0;
              count_r   <= '0;
              for (int j = 0; j < JOBS; j++) begin
                used_r[j]     <= 1'b0;
                device_r[j]   <= spds_pkg::DEV_UNSET;
                waiting_r[j]  <= 1'b0;
                force_r[j]    <= 1'b0;
                inflight_r[j] <= '0;
                streak_r[j]   <= '0;
                grants_r[j]   <= '0;
              end
            end
            default: state_r <= S_FIN;
          endcase
        end

        // priority pass: signed slack magnitude
        S_SLACK: begin
          if (used_r[i_r]) begin
            neg_r   <= diff_fw[63];
            mag_r   <= diff_fw[63] ? diff_bw : diff_fw;
            state_r <= S_MUL_LO;
          end else if (i_r == LAST_JOB) begin
            state_r <= S_NPU_CHECK;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end

        // low half through the shared multiplier
        S_MUL_LO: begin
          lo_r    <= 42'(mag_r[31:0]) * 42'(slack_gain_r);
          state_r <= S_MUL_HI;
        end

        // high half through the shared multiplier
        S_MUL_HI: begin
          hi_r    <= 42'(mag_r[63:32]) * 42'(slack_gain_r);
          state_r <= S_SUM;
        end

        // join the partial products
        S_SUM: begin
          sum_r   <= {hi_r, 32'b0} + 74'(lo_r);
          state_r <= S_PRIO_WR;
        end

        // saturate, apply the overdue penalty and store
        S_PRIO_WR: begin
          if (neg_r) begin
            if (sum_r >= 74'(spds_pkg::NEG_SAT_LIM)) begin
              prio_r[i_r] <= spds_pkg::PRIO_MIN;
            end else begin
              prio_r[i_r] <= 64'd0 - (sum_r[63:0] + spds_pkg::OVERDUE_PENALTY);
            end
          end else if (sum_r[73:63] != 11'd0) begin
            prio_r[i_r] <= spds_pkg::PRIO_MAX;
          end else begin
            prio_r[i_r] <= sum_r[63:0];
          end
          if (i_r == LAST_JOB) begin
            state_r <= S_NPU_CHECK;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_SLACK;
          end
        end

        // npu needs ring room and a free owner
        S_NPU_CHECK: begin
          i_r     <= '0;
          frc_v_r <= 1'b0;
          yld_v_r <= 1'b0;
          sel_v_r <= 1'b0;
          tgt_v_r <= 1'b0;
          state_r <= S_SCAN;
          if (count_r >= RING_FULL || owner_v_r) begin
            retry_npu_r <= 1'b1;
            scan_dev_r  <= spds_pkg::DEV_VPU;
          end else begin
            scan_dev_r <= spds_pkg::DEV_NPU;
          end
        end

        // one entry per cycle through the compare unit
        S_SCAN: begin
          if (elig && force_r[i_r]) begin
            frc_v_r <= 1'b1;
            frc_r   <= i_r;
            state_r <= S_GRANT;
          end else begin
            if (elig) begin
              if (yield_hit) begin
                yld_v_r <= 1'b1;
                yld_r   <= i_r;
              end else begin
                if (grant_win) begin
                  tgt_v_r   <= 1'b1;
                  tgt_r     <= i_r;
                  tgt_pri_r <= prio_r[i_r];
                  tgt_gr_r  <= grants_r[i_r];
                end
                if (prio_win) begin
                  sel_v_r   <= 1'b1;
                  sel_r     <= i_r;
                  sel_pri_r <= prio_r[i_r];
                  sel_gr_r  <= grants_r[i_r];
                end
              end
            end
            if (i_r == LAST_JOB) begin
              state_r <= S_GRANT;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
        end

        // dispatch the pick, then move on to the vpu or finish
        S_GRANT: begin
          if (pick_v) begin
            if (last_v_r && last_r == pick) begin
              if (streak_r[pick] != spds_pkg::STREAK_MAX) begin
                streak_r[pick] <= streak_r[pick] + 16'd1;
              end
            end else begin
              streak_r[pick] <= 16'd1;
            end
            if (grants_r[pick] != spds_pkg::GRANTS_MAX) begin
              grants_r[pick] <= grants_r[pick] + 32'd1;
            end
            if (inflight_r[pick] != spds_pkg::INFLIGHT_MAX) begin
              inflight_r[pick] <= inflight_r[pick] + 8'd1;
            end
            last_v_r        <= 1'b1;
            last_r          <= pick;
            force_r[pick]   <= 1'b0;
            waiting_r[pick] <= 1'b1;
          end
          if (scan_dev_r == spds_pkg::DEV_NPU) begin
            if (pick_v) begin
              owner_v_r <= 1'b1;
              owner_r   <= pick;
              tail_r    <= (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
              count_r   <= count_r + 1'b1;
              npu_gr_r  <= 1'b1;
              npu_job_r <= 4'(pick);
            end else begin
              retry_npu_r <= 1'b1;
            end
            i_r        <= '0;
            frc_v_r    <= 1'b0;
            yld_v_r    <= 1'b0;
            sel_v_r    <= 1'b0;
            tgt_v_r    <= 1'b0;
            scan_dev_r <= spds_pkg::DEV_VPU;
            state_r    <= S_SCAN;
          end else begin
            if (pick_v) begin
              vpu_gr_r  <= 1'b1;
              vpu_job_r <= 4'(pick);
            end else begin
              retry_vpu_r <= 1'b1;
            end
            state_r <= S_FIN;
          end
        end

        // show the result beat
        S_FIN: begin
          qcount_r    <= 3'(count_r);
          state_r     <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_npu_granted = npu_gr_r;
  assign out_npu_job     = npu_job_r;
  assign out_vpu_granted = vpu_gr_r;
  assign out_vpu_job     = vpu_job_r;
  assign out_retry_npu   = retry_npu_r;
  assign out_retry_vpu   = retry_vpu_r;
  assign out_popped_job  = popped_r;
  assign out_queue_count = qcount_r;

  // result beat only once the sequencer is back at rest
  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result beat while sequencer busy");

  // ring never overfills
  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RING_FULL)
    else $error("npu ring over capacity");

  // a granted npu beat never also asks for a retry
  a_npu_retry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && npu_gr_r) |-> !retry_npu_r)
    else $error("npu grant and retry together");

  // an npu grant leaves the owner taken and the ring non-empty
  a_npu_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GRANT && scan_dev_r == spds_pkg::DEV_NPU && pick_v) |=>
      (owner_v_r && count_r != '0))
    else $error("npu grant without owner or ring entry");

endmodule
